[src/slr_pkg.sv]
// Shared constants, types and helpers for the stereo linear resampler.
package slr_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int FRAC_BITS_DEF = 10;
    localparam int MAX_OUT       = 8;
    localparam int CNT_W         = $clog2(MAX_OUT);
    localparam int RATIO_EXTRA   = $clog2(MAX_OUT) + 1;
    localparam int DIV_BIT_W     = $clog2(SAMPLE_W);
    localparam int QUEUE_DEPTH   = 2;

    // Queue status seen by both ends.
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

    // Width of one packed job: four samples, ratio, start phase, count minus one.
    function automatic int job_width(input int frac);
        return 4 * SAMPLE_W + (frac + RATIO_EXTRA) + frac + CNT_W;
    endfunction

endpackage

[src/stereo_linear_resampler.sv]
// Stereo linear-interpolation sample rate converter, top level.
// Usage and timing: each input stereo frame request is taken whenever
// the two-entry job queue has room, so a burst of up to three frames
// (queue plus the job in progress) goes in back to back. A frame causes
// n = ceil((ratio - phase) / 2^FRAC_BITS) result requests, from none up to
// eight; frames that cause none only move the phase and shift the frame in.
// Every result passes through the back end in turn: a multiply state, a sum
// state, 16 restoring-divide steps (one quotient bit per cycle for both
// channels at once) and a handoff into the output register. Sustained
// throughput is set by the shared divider, which works on one result at a
// time while the queue takes further frames. The output register lets the
// back end start the next result while a finished one waits on stall. Write
// rate_ratio only while the block is idle; zero is taken as 1 and values
// above 8 << FRAC_BITS are clamped there.
module stereo_linear_resampler #(
    parameter int FRAC_BITS   = slr_pkg::FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = slr_pkg::QUEUE_DEPTH
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    // config
    input  logic                                       i_rate_ratio_we,
    input  logic [FRAC_BITS+slr_pkg::RATIO_EXTRA-1:0]  i_rate_ratio,
    // input frames
    input  logic                                       i_in_valid,
    output logic                                       o_in_stall,
    input  logic signed [slr_pkg::SAMPLE_W-1:0]        i_left_in,
    input  logic signed [slr_pkg::SAMPLE_W-1:0]        i_right_in,
    // results
    output logic                                       o_out_valid,
    input  logic                                       i_out_stall,
    output logic signed [slr_pkg::SAMPLE_W-1:0]        o_left_out,
    output logic signed [slr_pkg::SAMPLE_W-1:0]        o_right_out,
    output logic                                       o_last
);
    import slr_pkg::*;

    localparam int RW    = FRAC_BITS + RATIO_EXTRA;
    localparam int JOB_W = job_width(FRAC_BITS);
    localparam logic [RW-1:0] RATIO_ONE = RW'(1) << FRAC_BITS;
    localparam logic [RW-1:0] RATIO_MAX = RW'(MAX_OUT) << FRAC_BITS;

    logic [RW-1:0]    r_rate_ratio, n_rate_ratio;
    logic             push, pop;
    logic [JOB_W-1:0] push_job, head_job;
    t_fifo_status     q_status;

    // Clamp the written ratio into 1 .. 8 << FRAC_BITS.
    always_comb begin
        if (i_rate_ratio == '0) begin
            n_rate_ratio = RW'(1);
        end else if (i_rate_ratio > RATIO_MAX) begin
            n_rate_ratio = RATIO_MAX;
        end else begin
            n_rate_ratio = i_rate_ratio;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_ratio <= RATIO_ONE;
        end else if (i_rate_ratio_we) begin
            r_rate_ratio <= n_rate_ratio;
        end
    end

    // Front end: phase bookkeeping, frame history, job build.
    slr_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_left_in  (i_left_in),
        .i_right_in (i_right_in),
        .i_ratio    (r_rate_ratio),
        .i_status   (q_status),
        .o_push     (push),
        .o_job      (push_job)
    );

    // Job queue decoupling frame intake from the arithmetic.
    slr_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_wdata  (push_job),
        .i_pop    (pop),
        .o_rdata  (head_job),
        .o_status (q_status)
    );

    // Back end: multiply, sum, divide, result register.
    slr_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_status    (q_status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_left_out  (o_left_out),
        .o_right_out (o_right_out),
        .o_last      (o_last)
    );

endmodule

[src/slr_fifo.sv]
// Small register queue between the front end and the back end.
module slr_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = slr_pkg::QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic                 i_pop,
    output logic [WIDTH-1:0]     o_rdata,
    output slr_pkg::t_fifo_status o_status
);
    import slr_pkg::*;

    localparam int PTR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W  = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]   r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [COUNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + COUNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    assign o_rdata        = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == COUNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

[src/slr_front.sv]
// Front end: takes input frames, tracks phase and builds interpolation jobs.
module slr_front #(
    parameter int FRAC_BITS = slr_pkg::FRAC_BITS_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_in_valid,
    output logic                                         o_in_stall,
    input  logic signed [slr_pkg::SAMPLE_W-1:0]          i_left_in,
    input  logic signed [slr_pkg::SAMPLE_W-1:0]          i_right_in,
    input  logic [FRAC_BITS+slr_pkg::RATIO_EXTRA-1:0]    i_ratio,
    input  slr_pkg::t_fifo_status                        i_status,
    output logic                                         o_push,
    output logic [slr_pkg::job_width(FRAC_BITS)-1:0]     o_job
);
    import slr_pkg::*;

    localparam int PW = FRAC_BITS + RATIO_EXTRA;
    localparam logic [PW-1:0] STEP_M1 = (PW'(1) << FRAC_BITS) - PW'(1);

    logic signed [SAMPLE_W-1:0] r_prev_l, r_prev_r, r_cur_l, r_cur_r;
    logic [FRAC_BITS-1:0]       r_phase, n_phase;
    logic                       accept;
    logic                       has_out;
    logic [PW-1:0]              phase_w, span, settle;
    logic [RATIO_EXTRA-1:0]     out_cnt;
    logic [CNT_W-1:0]           cnt_m1;

    assign o_in_stall = i_status.full;
    assign accept     = i_in_valid && !i_status.full;

    // Results for this frame: ceil((ratio - phase) / step) when phase < ratio.
    always_comb begin
        phase_w = PW'(r_phase);
        has_out = (phase_w < i_ratio);
        span    = i_ratio - phase_w + STEP_M1;
        out_cnt = span[PW-1:FRAC_BITS];
        cnt_m1  = CNT_W'(out_cnt - RATIO_EXTRA'(1));
        if (has_out) begin
            settle = phase_w + {out_cnt, {FRAC_BITS{1'b0}}} - i_ratio;
        end else begin
            settle = phase_w - i_ratio;
        end
        n_phase = settle[FRAC_BITS-1:0];
    end

    assign o_push = accept && has_out;
    assign o_job  = {r_prev_l, r_prev_r, r_cur_l, r_cur_r, i_ratio, r_phase, cnt_m1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_l <= '0;
            r_prev_r <= '0;
            r_cur_l  <= '0;
            r_cur_r  <= '0;
            r_phase  <= '0;
        end else if (accept) begin
            r_prev_l <= r_cur_l;
            r_prev_r <= r_cur_r;
            r_cur_l  <= i_left_in;
            r_cur_r  <= i_right_in;
            r_phase  <= n_phase;
        end
    end

    // A pushed job always carries between one and MAX_OUT results.
    a_job_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (out_cnt != '0) && (out_cnt <= RATIO_EXTRA'(MAX_OUT)))
        else $error("job result count out of range");

endmodule

[src/slr_back.sv]
// Back end: per result multiply, sum and restoring divide, then output register.
module slr_back #(
    parameter int FRAC_BITS = slr_pkg::FRAC_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic [slr_pkg::job_width(FRAC_BITS)-1:0]  i_job,
    input  slr_pkg::t_fifo_status                     i_status,
    output logic                                      o_pop,
    output logic                                      o_out_valid,
    input  logic                                      i_out_stall,
    output logic signed [slr_pkg::SAMPLE_W-1:0]       o_left_out,
    output logic signed [slr_pkg::SAMPLE_W-1:0]       o_right_out,
    output logic                                      o_last
);
    import slr_pkg::*;

    localparam int PW     = FRAC_BITS + RATIO_EXTRA;
    localparam int PROD_W = SAMPLE_W + PW + 1;
    localparam int NUM_W  = PROD_W + 1;
    localparam int REM_W  = PW + SAMPLE_W - 1;
    localparam logic [PW-1:0] STEP = PW'(1) << FRAC_BITS;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_SUM  = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } t_back_state;

    t_back_state r_state, n_state;

    logic signed [SAMPLE_W-1:0] j_prev_l, j_prev_r, j_cur_l, j_cur_r;
    logic [PW-1:0]              j_ratio;
    logic [FRAC_BITS-1:0]       j_phase;
    logic [CNT_W-1:0]           j_cnt;

    logic signed [SAMPLE_W-1:0] r_prev_l, r_prev_r, r_cur_l, r_cur_r;
    logic signed [SAMPLE_W-1:0] n_prev_l, n_prev_r, n_cur_l, n_cur_r;
    logic [PW-1:0]              r_ratio, n_ratio, r_phase, n_phase;
    logic [CNT_W-1:0]           r_cnt, n_cnt, r_idx, n_idx;
    logic signed [PROD_W-1:0]   r_pa_l, r_pb_l, r_pa_r, r_pb_r;
    logic signed [PROD_W-1:0]   n_pa_l, n_pb_l, n_pa_r, n_pb_r;
    logic                       r_neg_l, r_neg_r, n_neg_l, n_neg_r;
    logic [REM_W-1:0]           r_rem_l, r_rem_r, n_rem_l, n_rem_r;
    logic [REM_W-1:0]           r_den, n_den;
    logic [SAMPLE_W-1:0]        r_q_l, r_q_r, n_q_l, n_q_r;
    logic [DIV_BIT_W-1:0]       r_bit, n_bit;
    logic                       r_out_valid, n_out_valid;
    logic [SAMPLE_W-1:0]        r_left_out, r_right_out, n_left_out, n_right_out;
    logic                       r_last, n_last;

    logic                       out_free, take_job, load_out;
    logic signed [PW:0]         wgt_a, wgt_b;
    logic signed [NUM_W-1:0]    num_l, num_r, mag_l, mag_r;
    logic                       ge_l, ge_r;

    assign {j_prev_l, j_prev_r, j_cur_l, j_cur_r, j_ratio, j_phase, j_cnt} = i_job;

    assign out_free = !r_out_valid || !i_out_stall;
    assign wgt_a    = {1'b0, r_ratio - r_phase};
    assign wgt_b    = {1'b0, r_phase};
    assign num_l    = {r_pa_l[PROD_W-1], r_pa_l} + {r_pb_l[PROD_W-1], r_pb_l};
    assign num_r    = {r_pa_r[PROD_W-1], r_pa_r} + {r_pb_r[PROD_W-1], r_pb_r};
    assign mag_l    = num_l[NUM_W-1] ? -num_l : num_l;
    assign mag_r    = num_r[NUM_W-1] ? -num_r : num_r;
    assign ge_l     = (r_rem_l >= r_den);
    assign ge_r     = (r_rem_r >= r_den);

    always_comb begin
        n_state     = r_state;
        n_prev_l    = r_prev_l;
        n_prev_r    = r_prev_r;
        n_cur_l     = r_cur_l;
        n_cur_r     = r_cur_r;
        n_ratio     = r_ratio;
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_pa_l      = r_pa_l;
        n_pb_l      = r_pb_l;
        n_pa_r      = r_pa_r;
        n_pb_r      = r_pb_r;
        n_neg_l     = r_neg_l;
        n_neg_r     = r_neg_r;
        n_rem_l     = r_rem_l;
        n_rem_r     = r_rem_r;
        n_den       = r_den;
        n_q_l       = r_q_l;
        n_q_r       = r_q_r;
        n_bit       = r_bit;
        n_left_out  = r_left_out;
        n_right_out = r_right_out;
        n_last      = r_last;
        take_job    = 1'b0;
        load_out    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (!i_status.empty) begin
                    take_job = 1'b1;
                end
            end
            S_MUL: begin
                n_pa_l  = PROD_W'(r_prev_l) * PROD_W'(wgt_a);
                n_pb_l  = PROD_W'(r_cur_l) * PROD_W'(wgt_b);
                n_pa_r  = PROD_W'(r_prev_r) * PROD_W'(wgt_a);
                n_pb_r  = PROD_W'(r_cur_r) * PROD_W'(wgt_b);
                n_state = S_SUM;
            end
            S_SUM: begin
                n_neg_l = num_l[NUM_W-1];
                n_neg_r = num_r[NUM_W-1];
                n_rem_l = mag_l[REM_W-1:0];
                n_rem_r = mag_r[REM_W-1:0];
                n_den   = {r_ratio, {(SAMPLE_W-1){1'b0}}};
                n_bit   = DIV_BIT_W'(SAMPLE_W - 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem_l = ge_l ? r_rem_l - r_den : r_rem_l;
                n_rem_r = ge_r ? r_rem_r - r_den : r_rem_r;
                n_q_l   = {r_q_l[SAMPLE_W-2:0], ge_l};
                n_q_r   = {r_q_r[SAMPLE_W-2:0], ge_r};
                n_den   = r_den >> 1;
                if (r_bit == '0) begin
                    n_state = S_OUT;
                end else begin
                    n_bit = r_bit - DIV_BIT_W'(1);
                end
            end
            S_OUT: begin
                if (out_free) begin
                    load_out    = 1'b1;
                    n_left_out  = r_neg_l ? -r_q_l : r_q_l;
                    n_right_out = r_neg_r ? -r_q_r : r_q_r;
                    n_last      = (r_idx == r_cnt);
                    if (r_idx == r_cnt) begin
                        if (!i_status.empty) begin
                            take_job = 1'b1;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_idx   = r_idx + CNT_W'(1);
                        n_phase = r_phase + STEP;
                        n_state = S_MUL;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (take_job) begin
            n_prev_l = j_prev_l;
            n_prev_r = j_prev_r;
            n_cur_l  = j_cur_l;
            n_cur_r  = j_cur_r;
            n_ratio  = j_ratio;
            n_phase  = PW'(j_phase);
            n_cnt    = j_cnt;
            n_idx    = '0;
            n_state  = S_MUL;
        end

        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_pop = take_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev_l    <= n_prev_l;
        r_prev_r    <= n_prev_r;
        r_cur_l     <= n_cur_l;
        r_cur_r     <= n_cur_r;
        r_ratio     <= n_ratio;
        r_phase     <= n_phase;
        r_cnt       <= n_cnt;
        r_idx       <= n_idx;
        r_pa_l      <= n_pa_l;
        r_pb_l      <= n_pb_l;
        r_pa_r      <= n_pa_r;
        r_pb_r      <= n_pb_r;
        r_neg_l     <= n_neg_l;
        r_neg_r     <= n_neg_r;
        r_rem_l     <= n_rem_l;
        r_rem_r     <= n_rem_r;
        r_den       <= n_den;
        r_q_l       <= n_q_l;
        r_q_r       <= n_q_r;
        r_bit       <= n_bit;
        r_left_out  <= n_left_out;
        r_right_out <= n_right_out;
        r_last      <= n_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_left_out  = r_left_out;
    assign o_right_out = r_right_out;
    assign o_last      = r_last;

    // Interpolation weight must stay non-negative.
    a_phase_below_ratio: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_phase < r_ratio))
        else $error("phase reached ratio inside a job");

    // Quotient fits in SAMPLE_W bits: remainder below twice the shifted divisor.
    a_div_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem_l < {r_den, 1'b0}) && (r_rem_r < {r_den, 1'b0}))
        else $error("divider remainder out of range");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_idx <= r_cnt))
        else $error("result index passed job count");

endmodule

[verif/stereo_linear_resampler_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the stereo resampler: predicts interpolated results and checks them in order.
module stereo_linear_resampler_checker #(
    parameter int FRAC_BITS = slr_pkg::FRAC_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_rate_ratio_we,
    input  logic [FRAC_BITS+slr_pkg::RATIO_EXTRA-1:0] i_rate_ratio,
    input  logic                                      i_in_valid,
    input  logic                                      i_in_stall,
    input  logic signed [slr_pkg::SAMPLE_W-1:0]       i_left_in,
    input  logic signed [slr_pkg::SAMPLE_W-1:0]       i_right_in,
    input  logic                                      i_out_valid,
    input  logic                                      i_out_stall,
    input  logic signed [slr_pkg::SAMPLE_W-1:0]       i_left_out,
    input  logic signed [slr_pkg::SAMPLE_W-1:0]       i_right_out,
    input  logic                                      i_last,
    output int                                        o_fail_count,
    output int                                        o_pending
);
    import slr_pkg::*;

    localparam int STEP      = 1 << FRAC_BITS;
    localparam int RATIO_MAX = MAX_OUT << FRAC_BITS;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        t_sample left;
        t_sample right;
        logic    last;
    } t_interp_result;

    t_interp_result interp_q[$];
    int             ratio;
    int             phase;
    t_sample        prev_l, prev_r, cur_l, cur_r;

    // Weighted blend, division truncates toward zero.
    function automatic t_sample blend(input t_sample a, input t_sample b,
                                      input int r, input int ph);
        longint num;
        longint quo;
        num = longint'(a) * longint'(r - ph) + longint'(b) * longint'(ph);
        quo = num / longint'(r);
        return quo[SAMPLE_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        o_fail_count++;
    endtask

    task automatic predict_frame(input t_sample l, input t_sample r);
        t_interp_result item;
        int             n;
        n = 0;
        while (phase < ratio && n < MAX_OUT) begin
            item.left  = blend(prev_l, cur_l, ratio, phase);
            item.right = blend(prev_r, cur_r, ratio, phase);
            item.last  = (phase + STEP >= ratio) || (n == MAX_OUT - 1);
            interp_q.push_back(item);
            phase += STEP;
            n++;
        end
        prev_l = cur_l;
        prev_r = cur_r;
        cur_l  = l;
        cur_r  = r;
        phase  = (phase >= ratio) ? phase - ratio : 0;
    endtask

    task automatic check_result();
        t_interp_result want;
        if (interp_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result L=%0d R=%0d last=%0b",
                                      i_left_out, i_right_out, i_last));
        end else begin
            want = interp_q.pop_front();
            if (i_left_out !== want.left)
                report_mismatch($sformatf("left_out got %0d expected %0d",
                                          i_left_out, want.left));
            if (i_right_out !== want.right)
                report_mismatch($sformatf("right_out got %0d expected %0d",
                                          i_right_out, want.right));
            if (i_last !== want.last)
                report_mismatch($sformatf("last got %0b expected %0b", i_last, want.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ratio  = STEP;
            phase  = 0;
            prev_l = '0;
            prev_r = '0;
            cur_l  = '0;
            cur_r  = '0;
            interp_q.delete();
        end else begin
            if (i_rate_ratio_we) begin
                if (i_rate_ratio == 0)
                    ratio = 1;
                else if (i_rate_ratio > RATIO_MAX)
                    ratio = RATIO_MAX;
                else
                    ratio = int'(i_rate_ratio);
            end
            if (i_in_valid && !i_in_stall)
                predict_frame(i_left_in, i_right_in);
            if (i_out_valid && !i_out_stall)
                check_result();
        end
        o_pending = interp_q.size();
    end

endmodule

[verif/stereo_linear_resampler_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the stereo resampler: frame stimulus, ratio writes, output stalls, verdict.
module stereo_linear_resampler_tb;
    import slr_pkg::*;

    localparam int FRAC    = FRAC_BITS_DEF;
    localparam int RATIO_W = FRAC + RATIO_EXTRA;

    // One frame at the ratio limit makes 8 results, each through the divider;
    // wait this long after the last predicted result arrives before touching
    // the ratio.
    localparam int DRAIN_CYCLES     = 200;
    localparam int WATCHDOG_LIMIT   = 5000;
    // Long output hold-off so the job queue fills and the input side stalls.
    localparam int HOLD_CYCLES      = 400;
    localparam int HOLD_AFTER       = 60;
    localparam int RANDOM_PHASES    = 5;
    localparam int RANDOM_PER_PHASE = 32;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_rate_ratio_we;
    logic [RATIO_W-1:0]         i_rate_ratio;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic signed [SAMPLE_W-1:0] i_left_in;
    logic signed [SAMPLE_W-1:0] i_right_in;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic signed [SAMPLE_W-1:0] o_left_out;
    logic signed [SAMPLE_W-1:0] o_right_out;
    logic                       o_last;

    int fail_count;
    int pending;
    int idle_cycles;
    int frames_sent;
    bit sender_steady;

    stereo_linear_resampler uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rate_ratio_we (i_rate_ratio_we),
        .i_rate_ratio    (i_rate_ratio),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_left_in       (i_left_in),
        .i_right_in      (i_right_in),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_left_out      (o_left_out),
        .o_right_out     (o_right_out),
        .o_last          (o_last)
    );

    stereo_linear_resampler_checker #(.FRAC_BITS(FRAC)) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rate_ratio_we (i_rate_ratio_we),
        .i_rate_ratio    (i_rate_ratio),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_left_in       (i_left_in),
        .i_right_in      (i_right_in),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_left_out      (o_left_out),
        .i_right_out     (o_right_out),
        .i_last          (o_last),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: any accepted request on either side restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("stereo_linear_resampler_tb NOT OK");
            $finish;
        end
    end

    // Offer one frame request and hold it until taken. Called and returns on a
    // falling edge; valid stays high on return so back-to-back frames never
    // drop and re-raise valid in one step.
    task automatic send_frame(input logic signed [SAMPLE_W-1:0] l,
                              input logic signed [SAMPLE_W-1:0] r);
        int gap;
        // every 16 frames pick whether this stretch runs with no gaps
        if (frames_sent % 16 == 0)
            sender_steady = ($urandom_range(0, 3) == 0);
        gap = sender_steady ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_left_in  <= l;
        i_right_in <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
        frames_sent++;
    endtask

    // Stop offering, wait for every predicted result, then wait out the
    // DRAIN_CYCLES margin.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Ratio may only change with the block idle.
    task automatic reconfigure(input logic [RATIO_W-1:0] val);
        drain();
        i_rate_ratio_we <= 1'b1;
        i_rate_ratio    <= val;
        @(negedge i_clk);
        i_rate_ratio_we <= 1'b0;
    endtask

    // Result sink: random stall before each result, occasional no-stall
    // stretches, and one long hold-off to back the block up.
    initial begin : result_sink
        int gap;
        int taken;
        bit steady;
        taken       = 0;
        steady      = 1'b0;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (taken % 16 == 0)
                steady = ($urandom_range(0, 3) == 0);
            gap = steady ? 0 : $urandom_range(0, 19);
            if (taken == HOLD_AFTER)
                gap = HOLD_CYCLES;
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            @(negedge i_clk);
            taken++;
        end
    end

    initial begin
        logic [RATIO_W-1:0] ratio_val;
        i_rst_n         = 1'b0;
        i_rate_ratio_we = 1'b0;
        i_rate_ratio    = '0;
        i_in_valid      = 1'b0;
        i_left_in       = '0;
        i_right_in      = '0;
        frames_sent     = 0;
        sender_steady   = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset ratio (one result per frame); first results blend the zero
        // frames held since reset.
        send_frame(16'sh7fff, -16'sh8000);
        send_frame(-16'sh8000, 16'sh7fff);
        send_frame(16'sh0000, -16'sh0001);
        send_frame(-16'sh0001, 16'sh0000);

        // All-ones write, above the limit: clamps to eight results per frame.
        reconfigure({RATIO_W{1'b1}});
        send_frame(16'sh7fff, 16'sh7fff);
        send_frame(-16'sh8000, -16'sh8000);
        send_frame(16'sh7fff, -16'sh8000);

        // Zero write clamps to 1: one result, then frames that make none.
        reconfigure('0);
        send_frame(16'sh1234, -16'sh1234);
        send_frame(-16'sh7fff, 16'sh7ffe);
        send_frame(16'sh5555, -16'sh5556);

        // Below one step: results on alternate frames only.
        reconfigure(RATIO_W'(512));
        send_frame(16'sh7fff, -16'sh8000);
        send_frame(-16'sh8000, 16'sh7fff);
        send_frame(16'sh0100, -16'sh0100);
        send_frame(-16'sh0001, 16'sh0001);

        // Non-integer ratio: phase walks through fractional positions.
        reconfigure(RATIO_W'(1536));
        send_frame(16'sh7fff, -16'sh8000);
        send_frame(-16'sh8000, 16'sh7fff);
        send_frame(16'sh2aaa, -16'sh2aab);
        send_frame(-16'sh0003, 16'sh0007);

        // Exactly at the limit.
        reconfigure(RATIO_W'(MAX_OUT << FRAC));
        send_frame(-16'sh8000, 16'sh7fff);
        send_frame(16'sh7fff, -16'sh8000);

        // Random frames across a spread of ratios; the first phase sits in the
        // clamped range so the long hold-off lands on a heavy load.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: ratio_val = RATIO_W'($urandom_range((MAX_OUT << FRAC) + 1,
                                                       (1 << RATIO_W) - 1));
                1: ratio_val = RATIO_W'($urandom_range(2 << FRAC, MAX_OUT << FRAC));
                2: ratio_val = RATIO_W'($urandom_range(300, (1 << FRAC) - 1));
                3: ratio_val = RATIO_W'($urandom_range(1 << FRAC, 4 << FRAC));
                default: ratio_val = RATIO_W'($urandom_range((4 << FRAC) + 1,
                                                             (MAX_OUT << FRAC) - 1));
            endcase
            reconfigure(ratio_val);
            repeat (RANDOM_PER_PHASE)
                send_frame(SAMPLE_W'($urandom), SAMPLE_W'($urandom));
        end

        drain();
        if (fail_count == 0 && pending == 0)
            $display("stereo_linear_resampler_tb OK");
        else
            $display("stereo_linear_resampler_tb NOT OK");
        $finish;
    end

endmodule
